[hw/rtl/ptt_pkg.sv]
// package for the periodic timer table
// shared types, operation and result kind codes, command/status structs
package ptt_pkg;

  localparam int unsigned EntriesDefault = 8;
  localparam int unsigned CatchupDefault = 7;
  localparam int unsigned IdWidthDefault = 32;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned PerW   = 32;
  localparam int unsigned TokW   = 32;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CountW = 4;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_TICK     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  typedef enum logic [KindW-1:0] {
    KIND_SCHED = 3'd0,
    KIND_CANCEL = 3'd1,
    KIND_FIRE  = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_CLEAR = 3'd4
  } kind_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic do_sched;   // write new entry, bump id counter
    logic do_clear;   // drop all entries
    logic cancel_step; // compact one slot
    logic cancel_init;
    logic eval;       // register the compare for the current entry
    logic fire;       // emit fire, advance due of current entry
    logic next_entry; // move walk pointer on
    logic walk_init;
    logic emit_reply; // load output with reply for the captured op
    logic emit_done;  // load output with tick done
  } ptt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       walk_end;  // pointer past last slot
    logic       due;       // registered: current entry due and cap not hit
    logic       skip_mode; // current entry in skip mode
  } ptt_sts_t;

  function automatic logic [TimeW-1:0] sat_add(logic [TimeW-1:0] a, logic [PerW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {{(TimeW-PerW+1){1'b0}}, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

endpackage

[hw/rtl/periodic_timer_table.sv]
// top level of the periodic timer table: stream ports, pause register,
// controller and datapath; depends on ptt_pkg, ptt_ctrl, ptt_datapath
//
// Each input beat is one operation: schedule, cancel, tick or clear. Schedule,
// clear and cancel reply with one beat; cancel first compacts the table one
// slot a cycle. Unless paused, a tick walks the table in insertion order,
// evaluating each entry and firing it when due (a catch-up entry up to
// Catchup times), and ends with a tick-done beat marked tlast. One operation
// is handled at a time; the next input beat can be taken while the previous
// result beat still waits.
module periodic_timer_table import ptt_pkg::*; #(
  parameter int unsigned Entries = EntriesDefault,
  parameter int unsigned Catchup = CatchupDefault,
  parameter int unsigned IdWidth = IdWidthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[1:0], now[49:2], period[81:50], drift_mode[82], token[114:83]
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic         m_axis_tlast,
  // timer_id[31:0], accepted[32], active_count[36:33]
  output logic [39:0]  m_axis_tdata,
  // kind[2:0]
  output logic [2:0]   m_axis_tuser
);

  logic     paused_q;
  ptt_cmd_t cmd;
  ptt_sts_t sts;
  logic [31:0] id;
  logic        acc;
  logic [CountW-1:0] cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) paused_q <= 1'b0;
    else if (cfg_we_i) paused_q <= cfg_wdata_i;
  end

  ptt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .out_valid_o (m_axis_tvalid), .out_ready_i (m_axis_tready),
    .out_last_o (m_axis_tlast), .paused_i (paused_q),
    .sts_i (sts), .cmd_o (cmd)
  );

  ptt_datapath #(.Entries(Entries), .Catchup(Catchup), .IdWidth(IdWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i (cmd), .sts_o (sts),
    .op_i (s_axis_tdata[1:0]), .now_i (s_axis_tdata[49:2]),
    .period_i (s_axis_tdata[81:50]), .comp_i (s_axis_tdata[82]),
    .token_i (s_axis_tdata[114:83]),
    .kind_o (m_axis_tuser), .id_o (id), .acc_o (acc), .count_o (cnt)
  );

  assign m_axis_tdata = {3'b000, cnt, acc, id};

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_FIRE |-> !m_axis_tlast)
    else $error("fire beat marked last");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[36:33] <= 4'(Entries))
    else $error("active count out of range");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while waiting");

endmodule

[hw/rtl/ptt_datapath.sv]
// datapath of the periodic timer table: entry registers, id counter,
// walk pointer, catch-up counter and output register; depends on ptt_pkg
module ptt_datapath import ptt_pkg::*; #(
  parameter int unsigned Entries = EntriesDefault,
  parameter int unsigned Catchup = CatchupDefault,
  parameter int unsigned IdWidth = IdWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptt_cmd_t            cmd_i,
  output ptt_sts_t            sts_o,
  input  logic [1:0]          op_i,
  input  logic [TimeW-1:0]    now_i,
  input  logic [PerW-1:0]     period_i,
  input  logic                comp_i,
  input  logic [TokW-1:0]     token_i,
  output logic [KindW-1:0]    kind_o,
  output logic [31:0]         id_o,
  output logic                acc_o,
  output logic [CountW-1:0]   count_o
);

  localparam int unsigned PtrW = $clog2(Entries + 1);
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CatW = $clog2(Catchup + 1);

  logic [1:0]       op_q;
  logic [TimeW-1:0] now_q;
  logic [PerW-1:0]  per_q;
  logic             comp_q;
  logic [TokW-1:0]  tok_q;

  logic [Entries-1:0]             val_q;
  logic [IdWidth-1:0]             eid_q  [Entries];
  logic [PerW-1:0]                eper_q [Entries];
  logic [TimeW-1:0]               edue_q [Entries];
  logic [Entries-1:0]             ecomp_q;
  logic [IdWidth-1:0]             idc_q;
  logic [PtrW-1:0]                rd_q, wr_q;
  logic [CatW-1:0]                fires_q;
  logic                           found_q, due_q;
  logic                           sched_ok_q;
  logic [CountW-1:0]              cnt;

  logic [IdxW-1:0] ri, wi;
  logic            r_match;
  logic [IdWidth-1:0] idc_inc;

  assign ri = rd_q[IdxW-1:0];
  assign wi = wr_q[IdxW-1:0];

  always_comb begin
    cnt = '0;
    for (int i = 0; i < Entries; i++) cnt = cnt + CountW'(val_q[i]);
  end

  assign r_match = (tok_q != '0) && (32'(eid_q[ri]) == tok_q);
  assign idc_inc = idc_q + IdWidth'(1);

  assign sts_o.op        = op_q;
  assign sts_o.walk_end  = (rd_q >= PtrW'(Entries)) || !val_q[ri];
  assign sts_o.due       = due_q;
  assign sts_o.skip_mode = !ecomp_q[ri];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q   <= '0;
      idc_q   <= IdWidth'(1);
      rd_q    <= '0;
      wr_q    <= '0;
      fires_q <= '0;
      found_q <= 1'b0;
      due_q   <= 1'b0;
    end else begin
      if (cmd_i.do_clear) val_q <= '0;
      if (cmd_i.do_sched && per_q != '0 && cnt < CountW'(Entries)) begin
        val_q[cnt[IdxW-1:0]] <= 1'b1;
        idc_q <= (idc_inc == '0) ? IdWidth'(1) : idc_inc;
      end
      if (cmd_i.cancel_init || cmd_i.walk_init) begin
        rd_q <= '0;
        wr_q <= '0;
        found_q <= 1'b0;
        fires_q <= '0;
      end
      if (cmd_i.cancel_step) begin
        // read slot rd, keep it at slot wr unless it matches
        if (rd_q < PtrW'(Entries)) begin
          if (val_q[ri] && r_match) begin
            found_q <= 1'b1;
            val_q[ri] <= 1'b0;
          end else if (val_q[ri]) begin
            if (wr_q != rd_q) val_q[ri] <= 1'b0;
            val_q[wi] <= 1'b1;
            wr_q <= wr_q + PtrW'(1);
          end
          rd_q <= rd_q + PtrW'(1);
        end
      end
      if (cmd_i.eval)
        due_q <= (now_q >= edue_q[ri]) && (!ecomp_q[ri] || fires_q < CatW'(Catchup));
      if (cmd_i.fire) begin
        fires_q <= fires_q + CatW'(1);
        due_q <= 1'b0;
      end
      if (cmd_i.next_entry) begin
        rd_q <= rd_q + PtrW'(1);
        fires_q <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i; now_q <= now_i; per_q <= period_i;
      comp_q <= comp_i; tok_q <= token_i;
    end
    if (cmd_i.do_sched && cnt < CountW'(Entries)) begin
      eid_q[cnt[IdxW-1:0]]  <= idc_q;
      eper_q[cnt[IdxW-1:0]] <= per_q;
      edue_q[cnt[IdxW-1:0]] <= sat_add(now_q, per_q);
      ecomp_q[cnt[IdxW-1:0]] <= comp_q;
    end
    if (cmd_i.cancel_step && rd_q < PtrW'(Entries) && val_q[ri] && !r_match
        && wr_q != rd_q) begin
      eid_q[wi] <= eid_q[ri]; eper_q[wi] <= eper_q[ri];
      edue_q[wi] <= edue_q[ri]; ecomp_q[wi] <= ecomp_q[ri];
    end
    if (cmd_i.fire)
      edue_q[ri] <= sat_add(ecomp_q[ri] ? edue_q[ri] : now_q, eper_q[ri]);
    if (cmd_i.fire) begin
      kind_o <= KIND_FIRE; id_o <= 32'(eid_q[ri]); acc_o <= 1'b0;
    end else if (cmd_i.emit_done) begin
      kind_o <= KIND_DONE; id_o <= '0; acc_o <= 1'b0;
    end else if (cmd_i.emit_reply) begin
      case (op_q)
        OP_SCHEDULE: begin
          kind_o <= KIND_SCHED;
          // reply follows do_sched: id counter already advanced
          if (per_q != '0 && cnt <= CountW'(Entries) && val_q[cnt[IdxW-1:0] - IdxW'(1)]
              && sched_ok_q) begin
            id_o <= 32'(eid_q[cnt[IdxW-1:0] - IdxW'(1)]); acc_o <= 1'b1;
          end else begin
            id_o <= '0; acc_o <= 1'b0;
          end
        end
        OP_CANCEL: begin kind_o <= KIND_CANCEL; id_o <= tok_q; acc_o <= found_q; end
        default:   begin kind_o <= KIND_CLEAR; id_o <= '0; acc_o <= 1'b0; end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sched_ok_q <= 1'b0;
    else if (cmd_i.do_sched) sched_ok_q <= per_q != '0 && cnt < CountW'(Entries);
  end

  // count sampled when the output register loads: reflects state after the op
  always_ff @(posedge clk_i) begin
    if (cmd_i.fire || cmd_i.emit_done || cmd_i.emit_reply) count_o <= cnt;
  end

endmodule

[hw/rtl/ptt_ctrl.sv]
// controller of the periodic timer table: sequences each operation
// and the output handshake; depends on ptt_pkg
module ptt_ctrl import ptt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output logic     out_last_o,
  input  logic     paused_i,
  input  ptt_sts_t sts_i,
  output ptt_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_OP    = 8'b0000_0010,
    S_CANC  = 8'b0000_0100,
    S_REPLY = 8'b0000_1000,
    S_EVAL  = 8'b0001_0000,
    S_DEC   = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_WAIT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   vld_q, vld_d, last_q, last_d;
  logic   out_free;
  logic   [3:0] cstep_q, cstep_d;

  assign out_free    = !vld_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = vld_q;
  assign out_last_o  = last_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    vld_d   = vld_q && !out_ready_i;
    last_d  = last_q;
    cstep_d = cstep_q;
    case (state_q)
      S_IDLE: if (in_valid_i && in_ready_o) begin
        cmd_o.load = 1'b1;
        state_d = S_OP;
      end
      S_OP: begin
        case (op_e'(sts_i.op))
          OP_SCHEDULE: begin cmd_o.do_sched = 1'b1; state_d = S_REPLY; end
          OP_CANCEL:   begin cmd_o.cancel_init = 1'b1; cstep_d = '0; state_d = S_CANC; end
          OP_CLEAR:    begin cmd_o.do_clear = 1'b1; state_d = S_REPLY; end
          default: begin
            cmd_o.walk_init = 1'b1;
            state_d = paused_i ? S_DONE : S_EVAL;
          end
        endcase
      end
      S_CANC: begin
        cmd_o.cancel_step = 1'b1;
        cstep_d = cstep_q + 4'd1;
        if (cstep_q == 4'd8) state_d = S_REPLY;
      end
      S_REPLY: if (out_free) begin
        cmd_o.emit_reply = 1'b1; vld_d = 1'b1; last_d = 1'b1; state_d = S_IDLE;
      end
      S_EVAL: begin
        if (sts_i.walk_end) state_d = S_DONE;
        else begin cmd_o.eval = 1'b1; state_d = S_DEC; end
      end
      S_DEC: begin
        if (sts_i.due) begin
          if (out_free) begin
            cmd_o.fire = 1'b1; vld_d = 1'b1; last_d = 1'b0;
            state_d = sts_i.skip_mode ? S_WAIT : S_EVAL;
          end
        end else begin
          cmd_o.next_entry = 1'b1; state_d = S_EVAL;
        end
      end
      S_WAIT: begin cmd_o.next_entry = 1'b1; state_d = S_EVAL; end
      S_DONE: if (out_free) begin
        cmd_o.emit_done = 1'b1; vld_d = 1'b1; last_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; vld_q <= 1'b0; last_q <= 1'b0;
      cstep_q <= '0;
    end else begin
      state_q <= state_d; vld_q <= vld_d; last_q <= last_d;
      cstep_q <= cstep_d;
    end
  end

endmodule
